/* hdl/assert_macros.svh */
// Assertion helpers used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Next-cycle implication that also runs during reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hdl/ffsl_pkg.sv */
package ffsl_pkg;

  localparam int unsigned CODE_COLUMNS_DEF = 72;

  localparam int unsigned IND_COL        = 6;
  localparam int unsigned FIRST_CODE_COL = 7;

  // Paragraph keywords that switch the rest of a line to verbatim.
  localparam int unsigned NUM_KW    = 6;
  localparam int unsigned KW_MAXLEN = 14;
  localparam int unsigned KW_POS_W  = $clog2(KW_MAXLEN);

  // Text is right-justified: the first character sits in the highest used byte.
  localparam logic [KW_MAXLEN*8-1:0] KW_TEXT [NUM_KW] = '{
    "AUTHOR.", "INSTALLATION.", "DATE-WRITTEN.",
    "DATE-COMPILED.", "SECURITY.", "REMARKS."
  };
  localparam logic [KW_POS_W:0] KW_LEN [NUM_KW] = '{
    (KW_POS_W+1)'(7), (KW_POS_W+1)'(13), (KW_POS_W+1)'(13),
    (KW_POS_W+1)'(14), (KW_POS_W+1)'(9), (KW_POS_W+1)'(8)
  };

  typedef struct packed {
    logic [NUM_KW-1:0] alive;  // keywords still matching after this byte
    logic              hit;    // a keyword matched in full on this byte
  } kw_result_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

endpackage

/* hdl/ffsl_kw_match.sv */
module ffsl_kw_match (
  input  logic [ffsl_pkg::KW_POS_W-1:0] pos,
  input  logic                          pos_ok,
  input  logic [7:0]                    up_byte,
  input  logic [ffsl_pkg::NUM_KW-1:0]   alive,
  output ffsl_pkg::kw_result_t          res
);

  always_comb begin
    logic [ffsl_pkg::KW_POS_W:0]   pos_x;
    logic [ffsl_pkg::KW_POS_W:0]   idx;
    logic [7:0]                    ch;
    res.alive = alive;
    res.hit   = 1'b0;
    pos_x     = {1'b0, pos};
    for (int k = 0; k < ffsl_pkg::NUM_KW; k++) begin
      idx = ffsl_pkg::KW_LEN[k] - pos_x - 1'b1;
      ch  = ffsl_pkg::KW_TEXT[k][{idx[ffsl_pkg::KW_POS_W-1:0], 3'b000} +: 8];
      if (alive[k]) begin
        if (pos_ok && (pos_x < ffsl_pkg::KW_LEN[k]) && (up_byte == ch)) begin
          if (pos_x + 1'b1 == ffsl_pkg::KW_LEN[k]) begin
            res.hit = 1'b1;
          end
        end else begin
          res.alive[k] = 1'b0;
        end
      end
    end
  end

endmodule

/* hdl/ffsl_core.sv */
module ffsl_core #(
  parameter int unsigned CODE_COLUMNS = ffsl_pkg::CODE_COLUMNS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [7:0] in_byte,
  output logic [7:0] out_byte
);

  localparam int unsigned ColW = $clog2(CODE_COLUMNS + 1);

  localparam logic [7:0] CHAR_LF     = 8'd10;
  localparam logic [7:0] CHAR_CR     = 8'd13;
  localparam logic [7:0] CHAR_STAR   = "*";
  localparam logic [7:0] CHAR_SLASH  = "/";
  localparam logic [7:0] CHAR_DOLLAR = "$";
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE = 8'h27;
  localparam logic [7:0] CHAR_EQUALS = "=";

  typedef enum logic [1:0] {
    MODE_CODE,
    MODE_LITERAL,
    MODE_PSEUDO
  } ctx_mode_t;

  logic [ColW-1:0]               col_r, col_nxt;
  logic                          cmt_r, cmt_nxt;
  ctx_mode_t                     mode_r, mode_nxt;
  logic [7:0]                    quote_r, quote_nxt;
  logic [7:0]                    prev_r, prev_nxt;
  logic [ffsl_pkg::NUM_KW-1:0]   alive_r, alive_nxt;
  logic                          para_r, para_nxt;

  logic [ColW-1:0]               pos;
  logic                          pos_ok;
  ffsl_pkg::kw_result_t          kw_res;

  assign pos    = col_r - ColW'(ffsl_pkg::FIRST_CODE_COL);
  assign pos_ok = col_r < ColW'(ffsl_pkg::FIRST_CODE_COL + ffsl_pkg::KW_MAXLEN);

  ffsl_kw_match u_kw (
    .pos     (pos[ffsl_pkg::KW_POS_W-1:0]),
    .pos_ok  (pos_ok),
    .up_byte (ffsl_pkg::to_upper(in_byte)),
    .alive   (alive_r),
    .res     (kw_res)
  );

  always_comb begin
    col_nxt   = col_r;
    cmt_nxt   = cmt_r;
    mode_nxt  = mode_r;
    quote_nxt = quote_r;
    prev_nxt  = in_byte;
    alive_nxt = alive_r;
    para_nxt  = para_r;
    out_byte  = in_byte;

    if (in_byte == CHAR_LF || in_byte == CHAR_CR) begin
      // A line break starts a fresh line.
      col_nxt   = '0;
      cmt_nxt   = 1'b0;
      mode_nxt  = MODE_CODE;
      quote_nxt = '0;
      prev_nxt  = '0;
      alive_nxt = '1;
      para_nxt  = 1'b0;
    end else begin
      if (col_r < ColW'(CODE_COLUMNS)) begin
        col_nxt = col_r + 1'b1;
      end
      if (col_r < ColW'(ffsl_pkg::IND_COL)) begin
        out_byte = in_byte;
      end else if (col_r == ColW'(ffsl_pkg::IND_COL)) begin
        out_byte = ffsl_pkg::to_lower(in_byte);
        if (in_byte == CHAR_STAR || in_byte == CHAR_SLASH || in_byte == CHAR_DOLLAR) begin
          cmt_nxt = 1'b1;
        end
      end else if (col_r >= ColW'(CODE_COLUMNS) || cmt_r || para_r) begin
        out_byte = in_byte;
      end else begin
        alive_nxt = kw_res.alive;
        if (kw_res.hit) begin
          para_nxt = 1'b1;
        end
        case (mode_r)
          MODE_LITERAL: begin
            out_byte = in_byte;
            if (in_byte == quote_r) begin
              mode_nxt = MODE_CODE;
            end
          end
          MODE_PSEUDO: begin
            out_byte = in_byte;
            if (prev_r == CHAR_EQUALS && in_byte == CHAR_EQUALS) begin
              mode_nxt = MODE_CODE;
            end
          end
          default: begin
            out_byte = ffsl_pkg::to_lower(in_byte);
            if (in_byte == CHAR_DQUOTE || in_byte == CHAR_SQUOTE) begin
              quote_nxt = in_byte;
              mode_nxt  = MODE_LITERAL;
            end else if (prev_r == CHAR_EQUALS && in_byte == CHAR_EQUALS) begin
              mode_nxt = MODE_PSEUDO;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      cmt_r   <= 1'b0;
      mode_r  <= MODE_CODE;
      quote_r <= '0;
      prev_r  <= '0;
      alive_r <= '1;
      para_r  <= 1'b0;
    end else if (en) begin
      col_r   <= col_nxt;
      cmt_r   <= cmt_nxt;
      mode_r  <= mode_nxt;
      quote_r <= quote_nxt;
      prev_r  <= prev_nxt;
      alive_r <= alive_nxt;
      para_r  <= para_nxt;
    end
  end

endmodule

/* hdl/fixed_format_source_lowercaser.sv */
// Lowercases fixed-format source text one byte at a time.
// The in_ channel takes one byte of text per request and the out_ channel
// returns exactly one byte per request, in order. CR and LF end a line.
// Columns 0 to 5 pass unchanged, the indicator column is lowercased, and the
// code area is lowercased except in comment lines, quoted literals, ==...==
// pseudotext and the rest of a line after an opening paragraph keyword.
// Bytes at or past CODE_COLUMNS pass unchanged.
// Each byte passes through one input register, then the per-line tracker
// between it and the output register.
// Throughput is one byte per cycle while the receiver accepts; the line state
// is updated as each byte moves on, so consecutive bytes flow without bubbles.
// The input is still accepted while a finished byte waits in the output
// register, as long as the input register is empty or can pass its byte on.
// When the receiver stalls, both registers fill and in_tready drops.
// A synchronous active-low reset empties both registers and returns the line
// state to the start of a line.
module fixed_format_source_lowercaser #(
  parameter int unsigned CODE_COLUMNS = ffsl_pkg::CODE_COLUMNS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [7:0] out_byte
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic [7:0] core_byte;
  logic       advance;

  // The held byte moves on when the output register is empty or being drained.
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  ffsl_core #(
    .CODE_COLUMNS (CODE_COLUMNS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .in_byte  (s1_byte_r),
    .out_byte (core_byte)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
    end
    if (advance) begin
      out_byte_r <= core_byte;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;

endmodule

/* hdl/ffsl_checker.sv */
`include "assert_macros.svh"

module ffsl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // Reset leaves the output empty and the input open.
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_tvalid && in_tready)

  // A receiver that takes data never throttles the input side.
  `ASSERT_IMPLY(a_ready_through, clk, rst_n, out_tready, in_tready)

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))

endmodule

bind fixed_format_source_lowercaser ffsl_checker u_ffsl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
